FILE: hw/rtl/mpd_pkg.sv
package mpd_pkg;

	// Register field widths
	localparam int TICK_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CHAR_W = 7;

	// Longest code held in the character table
	localparam int TABLE_SYMBOLS = 5;
	localparam int MAX_SYMBOLS_DEF = 5;

	// Reset values of the threshold registers
	localparam logic [TICK_W-1:0] DOT_FLOOR_RST = 16'd468;
	localparam logic [TICK_W-1:0] DOT_DASH_SPLIT_RST = 16'd3125;
	localparam logic [TICK_W-1:0] DASH_CEILING_RST = 16'd6250;
	localparam logic [TICK_W-1:0] LETTER_GAP_RST = 16'd15625;
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DOT_FLOOR = 2'd0,
		CFG_DOT_DASH_SPLIT = 2'd1,
		CFG_DASH_CEILING = 2'd2,
		CFG_LETTER_GAP = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_DOT = 2'd0,
		KIND_DASH = 2'd1,
		KIND_CHAR = 2'd2,
		KIND_ERROR = 2'd3
	} event_kind_t;

	// Threshold registers as seen by the symbol unit
	typedef struct packed {
		logic [TICK_W-1:0] dot_floor;
		logic [TICK_W-1:0] dot_dash_split;
		logic [TICK_W-1:0] dash_ceiling;
		logic [TICK_W-1:0] letter_gap;
	} thresh_t;

	// One result from the symbol unit
	typedef struct packed {
		logic valid;
		event_kind_t kind;
		logic [CHAR_W-1:0] code;
	} event_t;

	// Code lookup: bit i is symbol i (1 dash), first symbol in bit 0.
	// Returns 0 when there is no match.
	function automatic logic [CHAR_W-1:0] morse_lookup(input logic [2:0] len,
			input logic [TABLE_SYMBOLS-1:0] bits);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		case ({len, bits})
			{3'd1, 5'b00000}: ch = 7'h45; // E
			{3'd1, 5'b00001}: ch = 7'h54; // T
			{3'd2, 5'b00010}: ch = 7'h41; // A
			{3'd2, 5'b00000}: ch = 7'h49; // I
			{3'd2, 5'b00011}: ch = 7'h4D; // M
			{3'd2, 5'b00001}: ch = 7'h4E; // N
			{3'd3, 5'b00001}: ch = 7'h44; // D
			{3'd3, 5'b00011}: ch = 7'h47; // G
			{3'd3, 5'b00101}: ch = 7'h4B; // K
			{3'd3, 5'b00111}: ch = 7'h4F; // O
			{3'd3, 5'b00010}: ch = 7'h52; // R
			{3'd3, 5'b00000}: ch = 7'h53; // S
			{3'd3, 5'b00100}: ch = 7'h55; // U
			{3'd3, 5'b00110}: ch = 7'h57; // W
			{3'd4, 5'b00001}: ch = 7'h42; // B
			{3'd4, 5'b00101}: ch = 7'h43; // C
			{3'd4, 5'b00100}: ch = 7'h46; // F
			{3'd4, 5'b00000}: ch = 7'h48; // H
			{3'd4, 5'b01110}: ch = 7'h4A; // J
			{3'd4, 5'b00010}: ch = 7'h4C; // L
			{3'd4, 5'b00110}: ch = 7'h50; // P
			{3'd4, 5'b01011}: ch = 7'h51; // Q
			{3'd4, 5'b01000}: ch = 7'h56; // V
			{3'd4, 5'b01001}: ch = 7'h58; // X
			{3'd4, 5'b01101}: ch = 7'h59; // Y
			{3'd4, 5'b00011}: ch = 7'h5A; // Z
			{3'd5, 5'b11110}: ch = 7'h31; // 1
			{3'd5, 5'b11100}: ch = 7'h32; // 2
			{3'd5, 5'b11000}: ch = 7'h33; // 3
			{3'd5, 5'b10000}: ch = 7'h34; // 4
			{3'd5, 5'b00000}: ch = 7'h35; // 5
			{3'd5, 5'b00001}: ch = 7'h36; // 6
			{3'd5, 5'b00011}: ch = 7'h37; // 7
			{3'd5, 5'b00111}: ch = 7'h38; // 8
			{3'd5, 5'b01111}: ch = 7'h39; // 9
			{3'd5, 5'b11111}: ch = 7'h30; // 0
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

FILE: hw/rtl/morse_pulse_decoder.sv
// Channel   Direction  Handshake                  Payload
// line      in         line_valid / line_stall    line_level
// event     out        event_valid / event_stall  event_kind, char_code
// cfg       in         cfg_we                     cfg_index, cfg_wdata
//
// One sample is taken per cycle while line_stall is low. A sample is held
// in the input register, is processed against the pulse counters and the
// code table, and any result is registered in the result register.
// arst_n clears the counters, the code and the valid flags and loads the
// threshold registers with their defaults. A stalled result holds the sample
// behind it; the input register still fills, so line_stall rises only when
// both are occupied.
module morse_pulse_decoder #(
	parameter int MAX_SYMBOLS = mpd_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            line_valid,
	output logic                            line_stall,
	input  logic                            line_level,
	output logic                            event_valid,
	input  logic                            event_stall,
	output logic [1:0]                      event_kind,
	output logic [mpd_pkg::CHAR_W-1:0]      char_code,
	input  logic                            cfg_we,
	input  logic [mpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpd_pkg::TICK_W-1:0]      cfg_wdata
);
	import mpd_pkg::*;

	thresh_t           thr_q;
	logic              valid_s1;
	logic              level_s1;
	logic              advance;
	logic              go;
	event_t            evt;
	logic              event_valid_q;
	event_kind_t       event_kind_q;
	logic [CHAR_W-1:0] char_code_q;

	// Pipeline flow: the held sample moves on unless a result is stuck
	assign advance = !(event_valid_q && event_stall);
	assign go = valid_s1 && advance;
	assign line_stall = valid_s1 && !advance;

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.dot_floor <= DOT_FLOOR_RST;
			thr_q.dot_dash_split <= DOT_DASH_SPLIT_RST;
			thr_q.dash_ceiling <= DASH_CEILING_RST;
			thr_q.letter_gap <= LETTER_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DOT_FLOOR: thr_q.dot_floor <= cfg_wdata;
				CFG_DOT_DASH_SPLIT: thr_q.dot_dash_split <= cfg_wdata;
				CFG_DASH_CEILING: thr_q.dash_ceiling <= cfg_wdata;
				CFG_LETTER_GAP: thr_q.letter_gap <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Valid flags of the input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			event_valid_q <= 1'b0;
		end else begin
			if (!line_stall)
				valid_s1 <= line_valid;
			if (advance)
				event_valid_q <= go && evt.valid;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!line_stall && line_valid)
			level_s1 <= line_level;
		if (go && evt.valid) begin
			event_kind_q <= evt.kind;
			char_code_q <= evt.code;
		end
	end

	mpd_symbol_unit #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_symbol_unit (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.level(level_s1),
		.thr(thr_q),
		.evt(evt)
	);

	assign event_valid = event_valid_q;
	assign event_kind = event_kind_q;
	assign char_code = char_code_q;

endmodule

FILE: hw/rtl/mpd_symbol_unit.sv
module mpd_symbol_unit #(
	parameter int MAX_SYMBOLS = mpd_pkg::MAX_SYMBOLS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic            level,
	input  mpd_pkg::thresh_t thr,
	output mpd_pkg::event_t  evt
);
	import mpd_pkg::*;

	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

	logic              prev_level_q;
	logic [TICK_W-1:0] high_count_q;
	logic [TICK_W-1:0] low_count_q;
	logic [MAX_SYMBOLS-1:0] symbol_bits_q;
	logic [CNT_W-1:0]  symbol_count_q;
	logic              code_overflow_q;
	logic              decode_pending_q;

	logic              rise, fall, held_high, held_low;
	logic [TICK_W-1:0] low_inc;
	logic              pulse_ok, sym, code_full, decode;
	logic [CHAR_W-1:0] ch;
	logic              len_ok;

	// Edge detection
	assign rise = level & ~prev_level_q;
	assign fall = ~level & prev_level_q;
	assign held_high = level & prev_level_q;
	assign held_low = ~level & ~prev_level_q;

	// Pulse classification and gap test
	assign low_inc = (low_count_q != TICK_MAX) ? low_count_q + 1'b1 : low_count_q;
	assign pulse_ok = (high_count_q > thr.dot_floor) && (high_count_q <= thr.dash_ceiling);
	assign sym = high_count_q > thr.dot_dash_split;
	assign code_full = symbol_count_q >= CNT_W'(MAX_SYMBOLS);
	assign decode = held_low && decode_pending_q && (low_inc > thr.letter_gap);

	// Table lookup; codes longer than the table never match
	assign len_ok = symbol_count_q <= CNT_W'(TABLE_SYMBOLS);
	assign ch = (len_ok && !code_overflow_q) ?
		morse_lookup(3'(symbol_count_q), symbol_bits_q[TABLE_SYMBOLS-1:0]) : '0;

	// Result of this item
	always_comb begin
		evt = '{valid: 1'b0, kind: KIND_DOT, code: '0};
		if (fall && pulse_ok) begin
			evt.valid = 1'b1;
			evt.kind = sym ? KIND_DASH : KIND_DOT;
		end else if (decode) begin
			evt.valid = 1'b1;
			evt.kind = (ch != '0) ? KIND_CHAR : KIND_ERROR;
			evt.code = ch;
		end
	end

	// Counter and code state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			high_count_q <= '0;
			low_count_q <= '0;
			symbol_bits_q <= '0;
			symbol_count_q <= '0;
			code_overflow_q <= 1'b0;
			decode_pending_q <= 1'b0;
		end else if (go) begin
			prev_level_q <= level;
			if (rise) begin
				high_count_q <= TICK_W'(1);
				low_count_q <= '0;
				decode_pending_q <= 1'b0;
			end else if (held_high) begin
				if (high_count_q != TICK_MAX)
					high_count_q <= high_count_q + 1'b1;
			end else if (fall) begin
				low_count_q <= '0;
				decode_pending_q <= 1'b1;
				if (pulse_ok) begin
					if (!code_full) begin
						symbol_bits_q <= symbol_bits_q |
							(MAX_SYMBOLS'(sym) << symbol_count_q);
						symbol_count_q <= symbol_count_q + 1'b1;
					end else begin
						code_overflow_q <= 1'b1;
					end
				end
			end else begin
				low_count_q <= low_inc;
				if (decode) begin
					symbol_bits_q <= '0;
					symbol_count_q <= '0;
					code_overflow_q <= 1'b0;
					decode_pending_q <= 1'b0;
				end
			end
		end
	end

endmodule
